/* design/ils_pkg.sv */
// shared constants, codes and types of the indexed list store
package ils_pkg;

    // list capacity and derived widths
    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;
    localparam int COUNT_W  = 7;

    // request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_READ = 3'd0,
        OP_HEAD = 3'd1,
        OP_TAIL = 3'd2,
        OP_AT   = 3'd3,
        OP_DEL  = 3'd4
    } t_op;

    // response status codes
    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // shift command broadcast to every cell
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [CNT_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } t_shift_cmd;

endpackage

/* design/ils_if.sv */
// request and response channel interfaces of the indexed list store

interface ils_req_if;
    logic                        valid;
    logic                        ready;
    logic [ils_pkg::OP_W-1:0]    op;
    logic [ils_pkg::POS_W-1:0]   position;
    logic signed [ils_pkg::DATA_W-1:0] value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface ils_rsp_if;
    logic                           valid;
    logic                           ready;
    logic signed [ils_pkg::DATA_W-1:0] read_value;
    logic [ils_pkg::ST_W-1:0]       status;
    logic [ils_pkg::COUNT_W-1:0]    count;

    modport source (output valid, output read_value, output status, output count, input ready);
    modport sink   (input valid, input read_value, input status, input count, output ready);
endinterface

/* design/ils_cell.sv */
// one list slot: holds an entry and shifts toward head or tail on command
module ils_cell (
    input  logic                          i_clk,
    input  logic [ils_pkg::IDX_W-1:0]     i_index,
    input  ils_pkg::t_shift_cmd           i_cmd,
    input  logic [ils_pkg::DATA_W-1:0]    i_left,
    input  logic [ils_pkg::DATA_W-1:0]    i_right,
    input  logic [ils_pkg::CNT_W-1:0]     i_read_pos,
    output logic [ils_pkg::DATA_W-1:0]    o_value,
    output logic [ils_pkg::DATA_W-1:0]    o_read_data
);

    logic [ils_pkg::DATA_W-1:0] r_value;
    logic [ils_pkg::DATA_W-1:0] n_value;
    logic [ils_pkg::CNT_W-1:0]  idx_ext;

    assign idx_ext = ils_pkg::CNT_W'(i_index);

    // next slot content: on insert take from left, or the new value at the insert position; on delete take from right
    always_comb begin
        n_value = r_value;
        priority if (i_cmd.ins && (idx_ext > i_cmd.pos)) begin
            n_value = i_left;
        end else if (i_cmd.ins && (idx_ext == i_cmd.pos)) begin
            n_value = i_cmd.value;
        end else if (i_cmd.del && (idx_ext >= i_cmd.pos)) begin
            n_value = i_right;
        end else begin
            n_value = r_value;
        end
    end

    // slot storage, no reset needed
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // read contribution onto the or bus
    assign o_value     = r_value;
    assign o_read_data = (idx_ext == i_read_pos) ? r_value : '0;

endmodule

/* design/indexed_list_store.sv */
// top level of the indexed list store: cell chain, request decode, response register
//
//  channel | dir | handshake    | payload
//  i_req   | in  | valid/ready  | op, position, value
//  o_rsp   | out | valid/ready  | read_value, status, count
//
// one transaction per cycle while requests are taken: every request is decoded
// and applied to the cell chain in the cycle it is accepted; all later slots
// shift at once. the response appears in the response register in the next cycle.
// a request is taken while the response register is empty or being drained.
// synchronous active-low reset empties the list and the response register.
module indexed_list_store (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ils_req_if.sink  i_req,
    ils_rsp_if.source o_rsp
);

    localparam int N = ils_pkg::CAPACITY;

    logic [ils_pkg::CNT_W-1:0]  r_count;
    logic [ils_pkg::CNT_W-1:0]  n_count;
    logic                       r_rsp_valid;
    logic [ils_pkg::DATA_W-1:0] r_read_value;
    logic [ils_pkg::DATA_W-1:0] n_read_value;
    ils_pkg::t_status           r_status;
    ils_pkg::t_status           n_status;
    logic [ils_pkg::COUNT_W-1:0] r_count_out;

    logic                       accept;
    logic                       full;
    logic [ils_pkg::CMP_W-1:0]  pos_c;
    logic [ils_pkg::CMP_W-1:0]  cnt_c;
    ils_pkg::t_shift_cmd        cmd;
    logic [ils_pkg::DATA_W-1:0] cell_value [N];
    logic [ils_pkg::DATA_W-1:0] cell_rd    [N];
    logic [ils_pkg::DATA_W-1:0] read_bus;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign full        = (r_count == ils_pkg::CNT_W'(N));
    assign pos_c       = ils_pkg::CMP_W'(i_req.position);
    assign cnt_c       = ils_pkg::CMP_W'(r_count);

    // request decode: shift command, status, read value and new count
    always_comb begin
        cmd.ins      = 1'b0;
        cmd.del      = 1'b0;
        cmd.pos      = ils_pkg::CNT_W'(i_req.position);
        cmd.value    = i_req.value;
        n_count      = r_count;
        n_status     = ils_pkg::ST_DONE;
        n_read_value = '1;
        unique case (ils_pkg::t_op'(i_req.op))
            ils_pkg::OP_READ: begin
                if (pos_c < cnt_c) begin
                    n_read_value = read_bus;
                end else begin
                    n_status = ils_pkg::ST_RANGE;
                end
            end
            ils_pkg::OP_HEAD: begin
                cmd.pos = '0;
                if (full) begin
                    n_status = ils_pkg::ST_FULL;
                end else begin
                    cmd.ins = 1'b1;
                end
            end
            ils_pkg::OP_TAIL: begin
                cmd.pos = r_count;
                if (full) begin
                    n_status = ils_pkg::ST_FULL;
                end else begin
                    cmd.ins = 1'b1;
                end
            end
            ils_pkg::OP_AT: begin
                if (pos_c > cnt_c) begin
                    n_status = ils_pkg::ST_RANGE;
                end else if (full) begin
                    n_status = ils_pkg::ST_FULL;
                end else begin
                    cmd.ins = 1'b1;
                end
            end
            ils_pkg::OP_DEL: begin
                if (pos_c < cnt_c) begin
                    cmd.del = 1'b1;
                end else begin
                    n_status = ils_pkg::ST_RANGE;
                end
            end
            default: begin
                n_status = ils_pkg::ST_DONE;
            end
        endcase
        if (!accept) begin
            cmd.ins = 1'b0;
            cmd.del = 1'b0;
        end
        if (cmd.ins) begin
            n_count = r_count + ils_pkg::CNT_W'(1);
        end else if (cmd.del) begin
            n_count = r_count - ils_pkg::CNT_W'(1);
        end
    end

    // cell chain
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic [ils_pkg::DATA_W-1:0] left;
        logic [ils_pkg::DATA_W-1:0] right;
        if (g == 0) begin : g_first
            assign left = i_req.value;
        end else begin : g_mid_l
            assign left = cell_value[g-1];
        end
        if (g == N - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = cell_value[g+1];
        end
        ils_cell u_cell (
            .i_clk      (i_clk),
            .i_index    (ils_pkg::IDX_W'(g)),
            .i_cmd      (cmd),
            .i_left     (left),
            .i_right    (right),
            .i_read_pos (ils_pkg::CNT_W'(i_req.position)),
            .o_value    (cell_value[g]),
            .o_read_data(cell_rd[g])
        );
    end

    // or together the read contributions of all cells
    always_comb begin
        read_bus = '0;
        for (int k = 0; k < N; k++) begin
            read_bus = read_bus | cell_rd[k];
        end
    end

    // entry count and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
            r_count_out  <= ils_pkg::COUNT_W'(n_count);
        end
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.read_value = r_read_value;
    assign o_rsp.status     = r_status;
    assign o_rsp.count      = r_count_out;

endmodule
